### rtl/tdsr_pkg.sv
// package with shared types and constants of the timed decal slot ring
package tdsr_pkg;

	typedef enum logic [7:0] {
		ST_INIT = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_AGE  = 8'b0000_0100,
		ST_RD   = 8'b0000_1000,
		ST_CHK  = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_OUT  = 8'b0100_0000,
		ST_MARK = 8'b1000_0000
	} state_t;

	typedef enum logic {
		REG_ENABLE   = 1'b0,
		REG_DEF_LIFE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_SPAWN = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [31:0] tex;
		logic [31:0] rot;
		logic [31:0] rad;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} slot_data_t;

	typedef struct packed {
		logic [15:0] life;
		logic [15:0] age;
	} slot_time_t;

	localparam logic [15:0] DEF_LIFE_RESET = 16'd6000;
	localparam logic [7:0]  ALPHA_OPAQUE   = 8'd255;
	localparam logic [11:0] FADE_SCALE     = 12'd2550;

endpackage

### rtl/timed_decal_slot_ring.sv
// top level of the timed decal slot ring
// A spawn is written straight into both slot memories while idle. A tick runs an ageing pass
// through the slot time memory, then, when enabled, an emit pass with a result for each live
// slot, the alpha of a fading slot worked out first (one alpha quotient bit per cycle), and
// last the end marker. Results come out as a one-cycle strobe the receiver must take. After
// reset a clearing pass holds busy high; configuration writes are always taken.
module timed_decal_slot_ring
	import tdsr_pkg::*;
#(
	parameter int SLOT_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] radius,
	input  logic [31:0] rotation,
	input  logic [31:0] texture,
	input  logic [15:0] lifetime_ms,
	input  logic [15:0] delta_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [4:0]  slot_index,
	output logic        drawn,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_radius,
	output logic [31:0] out_rotation,
	output logic [31:0] out_texture,
	output logic [7:0]  alpha,
	output logic [5:0]  live_count,
	output logic        last
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	slot_time_t la_mem [SLOT_COUNT];
	slot_data_t dat_mem [SLOT_COUNT];

	state_t          state_q;
	logic            en_q;
	logic [15:0]     def_life_q;
	logic [IW-1:0]   head_q;
	logic [IW-1:0]   clr_idx_q;
	logic [IW-1:0]   ridx_q;
	logic            iss_done_q;
	logic            v_s1;
	logic [IW-1:0]   idx_s1;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   cnt_q;
	logic [15:0]     delta_q;
	slot_time_t      rd_la_q;
	slot_data_t      rd_dat_q;
	logic [25:0]     rem_q;
	logic [24:0]     dvs_q;
	logic [7:0]      quo_q;
	logic [2:0]      k_q;
	logic [7:0]      alpha_q;

	logic            la_we;
	logic [IW-1:0]   la_waddr;
	slot_time_t      la_wdata;
	logic            la_re;
	logic [IW-1:0]   raddr;
	logic            spawn_ok;
	logic [16:0]     new_age;
	logic [18:0]     age5;
	logic [18:0]     life4;
	logic [7:0]      quo_nxt;
	logic [25:0]     rem_nxt;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign spawn_ok  = start && !busy && (command == CMD_SPAWN) && en_q && (texture != 32'd0);
	assign new_age   = {1'b0, rd_la_q.age} + {1'b0, delta_q};
	assign age5      = 19'(rd_la_q.age) * 19'd5;
	assign life4     = {1'b0, rd_la_q.life, 2'b00};
	assign la_re     = (state_q == ST_AGE && !iss_done_q) || (state_q == ST_RD);
	assign raddr     = (state_q == ST_AGE) ? ridx_q : idx_q;

	always_comb begin
		if (rem_q >= {1'b0, dvs_q}) begin
			rem_nxt = rem_q - {1'b0, dvs_q};
			quo_nxt = {quo_q[6:0], 1'b1};
		end else begin
			rem_nxt = rem_q;
			quo_nxt = {quo_q[6:0], 1'b0};
		end
	end

	always_comb begin
		la_we    = 1'b0;
		la_waddr = head_q;
		la_wdata = '0;
		if (state_q == ST_INIT) begin
			la_we    = 1'b1;
			la_waddr = clr_idx_q;
		end else if (spawn_ok) begin
			la_we         = 1'b1;
			la_wdata.life = (lifetime_ms != 16'd0) ? lifetime_ms : def_life_q;
		end else if (state_q == ST_AGE && v_s1 && en_q && rd_la_q.life != 16'd0) begin
			la_we    = 1'b1;
			la_waddr = idx_s1;
			if (new_age < {1'b0, rd_la_q.life}) begin
				la_wdata.life = rd_la_q.life;
				la_wdata.age  = new_age[15:0];
			end
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (la_we) begin
			la_mem[la_waddr] <= la_wdata;
		end
		if (la_re) begin
			rd_la_q <= la_mem[raddr];
		end
		if (spawn_ok) begin
			dat_mem[head_q] <= '{tex: texture, rot: rotation, rad: radius,
				z: pos_z, y: pos_y, x: pos_x};
		end
		if (state_q == ST_RD) begin
			rd_dat_q <= dat_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b0;
			def_life_q <= DEF_LIFE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:   en_q       <= cfg_data[0];
				REG_DEF_LIFE: def_life_q <= cfg_data;
				default:      en_q       <= en_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			head_q     <= '0;
			clr_idx_q  <= '0;
			ridx_q     <= '0;
			iss_done_q <= 1'b0;
			v_s1       <= 1'b0;
			idx_s1     <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			delta_q    <= '0;
			rem_q      <= '0;
			dvs_q      <= '0;
			quo_q      <= '0;
			k_q        <= '0;
			alpha_q    <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (spawn_ok) begin
						head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
					end
					if (start && command == CMD_TICK) begin
						state_q    <= ST_AGE;
						ridx_q     <= '0;
						iss_done_q <= 1'b0;
						v_s1       <= 1'b0;
						cnt_q      <= '0;
						delta_q    <= (delta_ms == 16'd0) ? 16'd1 : delta_ms;
					end
				end
				ST_AGE: begin
					v_s1   <= !iss_done_q;
					idx_s1 <= ridx_q;
					if (!iss_done_q) begin
						ridx_q <= ridx_q + 1'b1;
						if (ridx_q == LAST_IDX) begin
							iss_done_q <= 1'b1;
						end
					end
					if (v_s1) begin
						if (rd_la_q.life != 16'd0 &&
							(!en_q || new_age < {1'b0, rd_la_q.life})) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= en_q ? ST_RD : ST_MARK;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (rd_la_q.life == 16'd0) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == LAST_IDX) ? ST_MARK : ST_RD;
					end else if (age5 < life4) begin
						alpha_q <= ALPHA_OPAQUE;
						state_q <= ST_OUT;
					end else begin
						rem_q   <= 26'(FADE_SCALE) * 26'(rd_la_q.life - rd_la_q.age)
							+ 26'(rd_la_q.life);
						dvs_q   <= {1'b0, rd_la_q.life, 8'd0};
						quo_q   <= '0;
						k_q     <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q   <= rem_nxt;
					quo_q   <= quo_nxt;
					alpha_q <= quo_nxt;
					dvs_q   <= dvs_q >> 1;
					k_q     <= k_q + 1'b1;
					if (k_q == 3'd7) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == LAST_IDX) ? ST_MARK : ST_RD;
				end
				ST_MARK: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		result_valid = (state_q == ST_OUT) || (state_q == ST_MARK);
		drawn        = (state_q == ST_OUT);
		last         = (state_q == ST_MARK);
		live_count   = 6'(cnt_q);
		slot_index   = '0;
		out_x        = '0;
		out_y        = '0;
		out_z        = '0;
		out_radius   = '0;
		out_rotation = '0;
		out_texture  = '0;
		alpha        = '0;
		if (state_q == ST_OUT) begin
			slot_index   = 5'(idx_q);
			out_x        = rd_dat_q.x;
			out_y        = rd_dat_q.y;
			out_z        = rd_dat_q.z;
			out_radius   = rd_dat_q.rad;
			out_rotation = rd_dat_q.rot;
			out_texture  = rd_dat_q.tex;
			alpha        = alpha_q;
		end
	end

`ifndef SYNTHESIS
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_TICK |=> busy)
		else $error("tick request did not start the ageing pass");
	a_drawn_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && drawn |-> cnt_q != '0)
		else $error("slot emitted with zero live count");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && k_q == 3'd7 |=> state_q == ST_OUT)
		else $error("alpha division did not end in a result");
	a_no_spawn_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !spawn_ok)
		else $error("spawn written while busy");
`endif

endmodule
